>>> rtl/sjf_pkg.sv
// Shared definitions for the shortest-job-first scheduler.
// Holds field widths, request and status codes, and the queue entry type.
`default_nettype none

package sjf_pkg;

  localparam int ID_W        = 8;
  localparam int BURST_W     = 16;
  localparam int TIME_W      = 32;
  localparam int QUEUE_DEPTH = 16;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/sjf_if.sv
// Valid/ready channel interfaces for the scheduler's request and result streams.
// Depends on sjf_pkg for the field widths.
`default_nettype none

interface sjf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [sjf_pkg::ID_W-1:0]    job_id;
  logic [sjf_pkg::BURST_W-1:0] burst_len;

  modport source (output valid, req_type, job_id, burst_len, input ready);
  modport sink (input valid, req_type, job_id, burst_len, output ready);
endinterface

interface sjf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic [sjf_pkg::ID_W-1:0]   done_id;
  logic [sjf_pkg::TIME_W-1:0] turnaround;
  logic [sjf_pkg::TIME_W-1:0] waiting;

  modport source (output valid, status, done_id, turnaround, waiting, input ready);
  modport sink (input valid, status, done_id, turnaround, waiting, output ready);
endinterface

`default_nettype wire

>>> rtl/sjf_ram.sv
// Ready-queue storage: one write port and one read port with registered read data.
// Depends on sjf_pkg for the entry type.
`default_nettype none

module sjf_ram #(
  parameter int DEPTH = sjf_pkg::QUEUE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire sjf_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output sjf_pkg::entry_t      rdata
);

  sjf_pkg::entry_t mem [DEPTH];
  sjf_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/sjf_pick.sv
// Running best-candidate register for the ready-queue scan.
// Orders by least burst, then greatest age, then lowest id; earlier slot wins ties.
`default_nettype none

module sjf_pick #(
  parameter int AW = $clog2(sjf_pkg::QUEUE_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clear,
  input  wire logic                      cand_valid,
  input  wire sjf_pkg::entry_t           cand,
  input  wire logic [AW-1:0]             cand_slot,
  input  wire logic [sjf_pkg::TIME_W-1:0] tick,
  output logic                           found,
  output sjf_pkg::entry_t                best,
  output logic [AW-1:0]                  best_slot
);

  logic                        found_r;
  sjf_pkg::entry_t             best_r;
  logic [AW-1:0]               slot_r;
  logic [sjf_pkg::TIME_W-1:0]  age_cand;
  logic [sjf_pkg::TIME_W-1:0]  age_best;
  logic                        take;

  assign age_cand = tick - cand.arrival;
  assign age_best = tick - best_r.arrival;

  always_comb begin
    take = 1'b0;
    if (cand_valid) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (cand.burst != best_r.burst) begin
        take = cand.burst < best_r.burst;
      end else if (age_cand != age_best) begin
        take = age_cand > age_best;
      end else begin
        take = cand.id < best_r.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !clear) begin
      best_r <= cand;
      slot_r <= cand_slot;
    end
  end

  assign found     = found_r;
  assign best      = best_r;
  assign best_slot = slot_r;

endmodule

`default_nettype wire

>>> rtl/sjf_nonpreemptive_scheduler.sv
// Non-preemptive shortest-job-first scheduler, top level.
// Uses sjf_pkg, sjf_if, sjf_ram and sjf_pick.
//
// The request channel carries arrival and tick transactions; the result
// channel carries completion and reject transactions, zero or one per request.
// An arrival scans the valid bits for the lowest free slot, one slot per
// cycle, and writes the job into the queue memory.
// A full queue turns the arrival into a reject result.
// A tick while a job is counting down only decrements its remaining burst
// and advances the tick counter. A tick with the processor idle, or retiring
// a finished job, reads every queue slot through the memory's single read
// port, one per cycle, keeps the best candidate, then hands over any result.
// Results sit in an output register; the block keeps taking requests while a
// result waits and only stalls when a second result must be handed over.
// Reset empties the queue, idles the processor and zeroes the tick counter;
// the queue memory itself is not cleared.
`default_nettype none

module sjf_nonpreemptive_scheduler #(
  parameter int QUEUE_DEPTH = sjf_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sjf_in_if.sink    in_ch,
  sjf_out_if.source out_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = sjf_pkg::TIME_W;
  localparam int BW = sjf_pkg::BURST_W;
  localparam int IW = sjf_pkg::ID_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_FREE = 5'b00010,
    ST_PICK = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_PUSH = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          scan_idx_r, scan_idx_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [TW-1:0]          tick_r, tick_nxt;
  logic                   running_r, running_nxt;
  logic [IW-1:0]          run_id_r, run_id_nxt;
  logic [TW-1:0]          run_arrival_r, run_arrival_nxt;
  logic [BW-1:0]          run_burst_r, run_burst_nxt;
  logic [BW-1:0]          remaining_r, remaining_nxt;
  logic [IW-1:0]          arr_id_r, arr_id_nxt;
  logic [BW-1:0]          arr_burst_r, arr_burst_nxt;
  logic                   pend_r, pend_nxt;
  logic                   pend_status_r, pend_status_nxt;
  logic [IW-1:0]          pend_id_r, pend_id_nxt;
  logic [TW-1:0]          pend_ta_r, pend_ta_nxt;
  logic [TW-1:0]          pend_wt_r, pend_wt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_status_r, out_status_nxt;
  logic [IW-1:0]          out_id_r, out_id_nxt;
  logic [TW-1:0]          out_ta_r, out_ta_nxt;
  logic [TW-1:0]          out_wt_r, out_wt_nxt;
  logic                   cand_v_r;
  logic [AW-1:0]          cand_slot_r;

  logic                   in_acc;
  logic [AW-1:0]          slot;
  logic [TW-1:0]          done_ta;
  logic [TW-1:0]          done_wt;
  logic                   ram_we;
  sjf_pkg::entry_t        ram_wdata;
  sjf_pkg::entry_t        ram_rdata;
  logic                   pick_clear;
  logic                   pick_found;
  sjf_pkg::entry_t        pick_best;
  logic [AW-1:0]          pick_slot;

  assign slot    = scan_idx_r[AW-1:0];
  assign done_ta = tick_r - run_arrival_r;
  assign done_wt = done_ta - TW'(run_burst_r);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc  = in_ch.valid && (state_r == ST_IDLE);

  assign ram_wdata.id      = arr_id_r;
  assign ram_wdata.burst   = arr_burst_r;
  assign ram_wdata.arrival = tick_r;

  sjf_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  sjf_pick #(
    .AW (AW)
  ) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (pick_clear),
    .cand_valid (cand_v_r),
    .cand       (ram_rdata),
    .cand_slot  (cand_slot_r),
    .tick       (tick_r),
    .found      (pick_found),
    .best       (pick_best),
    .best_slot  (pick_slot)
  );

  always_comb begin
    state_nxt       = state_r;
    scan_idx_nxt    = scan_idx_r;
    valid_nxt       = valid_r;
    tick_nxt        = tick_r;
    running_nxt     = running_r;
    run_id_nxt      = run_id_r;
    run_arrival_nxt = run_arrival_r;
    run_burst_nxt   = run_burst_r;
    remaining_nxt   = remaining_r;
    arr_id_nxt      = arr_id_r;
    arr_burst_nxt   = arr_burst_r;
    pend_nxt        = pend_r;
    pend_status_nxt = pend_status_r;
    pend_id_nxt     = pend_id_r;
    pend_ta_nxt     = pend_ta_r;
    pend_wt_nxt     = pend_wt_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_id_nxt      = out_id_r;
    out_ta_nxt      = out_ta_r;
    out_wt_nxt      = out_wt_r;
    ram_we          = 1'b0;
    pick_clear      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == sjf_pkg::REQ_ARRIVAL) begin
            arr_id_nxt    = in_ch.job_id;
            arr_burst_nxt = in_ch.burst_len;
            scan_idx_nxt  = '0;
            state_nxt     = ST_FREE;
          end else if (running_r && (remaining_r != '0)) begin
            remaining_nxt = remaining_r - 1'b1;
            tick_nxt      = tick_r + 1'b1;
          end else begin
            pend_nxt        = running_r;
            pend_status_nxt = sjf_pkg::STATUS_DONE;
            pend_id_nxt     = run_id_r;
            pend_ta_nxt     = done_ta;
            pend_wt_nxt     = done_wt;
            running_nxt     = 1'b0;
            scan_idx_nxt    = '0;
            pick_clear      = 1'b1;
            state_nxt       = ST_PICK;
          end
        end
      end
      ST_FREE: begin
        if (!valid_r[slot]) begin
          ram_we          = 1'b1;
          valid_nxt[slot] = 1'b1;
          state_nxt       = ST_IDLE;
        end else if (scan_idx_r == CW'(QUEUE_DEPTH - 1)) begin
          pend_nxt        = 1'b1;
          pend_status_nxt = sjf_pkg::STATUS_REJECT;
          pend_id_nxt     = arr_id_r;
          pend_ta_nxt     = '0;
          pend_wt_nxt     = '0;
          state_nxt       = ST_PUSH;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_PICK: begin
        if (scan_idx_r == CW'(QUEUE_DEPTH)) begin
          state_nxt = ST_FIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_FIN: begin
        tick_nxt = tick_r + 1'b1;
        if (pick_found) begin
          running_nxt          = 1'b1;
          run_id_nxt           = pick_best.id;
          run_arrival_nxt      = pick_best.arrival;
          run_burst_nxt        = pick_best.burst;
          remaining_nxt        = (pick_best.burst != '0) ? pick_best.burst - 1'b1 : '0;
          valid_nxt[pick_slot] = 1'b0;
        end
        state_nxt = pend_r ? ST_PUSH : ST_IDLE;
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_id_nxt     = pend_id_r;
          out_ta_nxt     = pend_ta_r;
          out_wt_nxt     = pend_wt_r;
          pend_nxt       = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      valid_r       <= '0;
      tick_r        <= '0;
      running_r     <= 1'b0;
      run_id_r      <= '0;
      run_arrival_r <= '0;
      run_burst_r   <= '0;
      remaining_r   <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      cand_v_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      valid_r       <= valid_nxt;
      tick_r        <= tick_nxt;
      running_r     <= running_nxt;
      run_id_r      <= run_id_nxt;
      run_arrival_r <= run_arrival_nxt;
      run_burst_r   <= run_burst_nxt;
      remaining_r   <= remaining_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
      cand_v_r      <= (state_r == ST_PICK) && (scan_idx_r < CW'(QUEUE_DEPTH)) &&
                       valid_r[slot];
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r    <= scan_idx_nxt;
    arr_id_r      <= arr_id_nxt;
    arr_burst_r   <= arr_burst_nxt;
    pend_status_r <= pend_status_nxt;
    pend_id_r     <= pend_id_nxt;
    pend_ta_r     <= pend_ta_nxt;
    pend_wt_r     <= pend_wt_nxt;
    out_status_r  <= out_status_nxt;
    out_id_r      <= out_id_nxt;
    out_ta_r      <= out_ta_nxt;
    out_wt_r      <= out_wt_nxt;
    cand_slot_r   <= slot;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.done_id    = out_id_r;
  assign out_ch.turnaround = out_ta_r;
  assign out_ch.waiting    = out_wt_r;

`ifndef SYNTH
  a_remaining_bound: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (remaining_r <= run_burst_r))
    else $error("remaining burst exceeds the running job's burst");

  a_start_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && pick_found |=> running_r && !valid_r[$past(pick_slot)])
    else $error("started job still marked valid in the ready queue");

  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (tick_r == TW'($past(tick_r) + 1'b1)))
    else $error("tick counter did not advance at the end of a scan");
`endif

endmodule

`default_nettype wire
